[src/bcdf_pkg.sv]
package bcdf_pkg;

  // Result codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_DIGIT    = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW = 3'd2;
  localparam logic [2:0] ERR_LENGTH   = 3'd3;
  localparam logic [2:0] ERR_RANGE    = 3'd4;

  localparam logic [2:0] TIME_BYTES   = 3'd6;
  localparam logic [2:0] COUNT_MAX    = 3'd7;

  // Time accumulator width: a day in ns fits in 47 bits
  localparam int unsigned TNS_W = 47;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  error;
  } out_t;

  typedef struct packed {
    logic digit_bad;
    logic overflow;
    logic range_bad;
  } step_flags_t;

  typedef struct packed {
    logic [TNS_W-1:0] w_hi;
    logic [TNS_W-1:0] w_lo;
  } weight_pair_t;

  // ns weight of the high and low digit of each time byte, HH MM SS mmm uuu
  function automatic weight_pair_t time_weights(input logic [2:0] idx);
    weight_pair_t w;
    case (idx)
      3'd0: begin
        w.w_hi = 47'd36_000_000_000_000;
        w.w_lo = 47'd3_600_000_000_000;
      end
      3'd1: begin
        w.w_hi = 47'd600_000_000_000;
        w.w_lo = 47'd60_000_000_000;
      end
      3'd2: begin
        w.w_hi = 47'd10_000_000_000;
        w.w_lo = 47'd1_000_000_000;
      end
      3'd3: begin
        w.w_hi = 47'd100_000_000;
        w.w_lo = 47'd10_000_000;
      end
      3'd4: begin
        w.w_hi = 47'd1_000_000;
        w.w_lo = 47'd100_000;
      end
      3'd5: begin
        w.w_hi = 47'd10_000;
        w.w_lo = 47'd1_000;
      end
      default: begin
        w.w_hi = '0;
        w.w_lo = '0;
      end
    endcase
    return w;
  endfunction

endpackage

[src/bcd_field_to_binary.sv]
// Packed BCD field to binary converter.
//
// Byte channel (byte_valid / byte_stall / byte_req): one packed BCD byte per
// request, high nibble the more significant digit. kind is sampled on the first
// byte of a field only; last closes the field.
// Result channel (result_valid / result_stall / result_req): one request per
// field, issued for its last byte: the integer, or the time of day in ns, or
// zero with an error code (1 bad digit, 2 overflow, 3 time length, 4 range).
//
// Timing: a byte is registered in s1 on acceptance and processed from s1;
// a last byte's result is registered as s1 moves on. One byte per cycle holds
// unless a last byte waits on a stalled result. The per-byte path is one constant
// multiply-add (acc*100 + two digits) between the input and state registers.
//
// Stall: bytes that close no field always drain, so only a last byte waiting on
// a full, stalled result register holds off the byte channel.
// Reset (rst, synchronous): both channels go empty and the next byte opens a
// new field.
module bcd_field_to_binary
  import bcdf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic byte_valid,
  output logic byte_stall,
  input  in_t  byte_req,
  output logic result_valid,
  input  logic result_stall,
  output out_t result_req
);

  // input register
  logic s1_valid;
  in_t  s1;

  // field state
  logic [63:0]      acc;
  logic [TNS_W-1:0] tns;
  logic [2:0]       count;
  logic [2:0]       ferr;
  logic             fkind;
  logic             fopen;
  logic             rng;

  // field state as seen by the byte in s1 (cleared on a field's first byte)
  logic [63:0]      acc_b;
  logic [TNS_W-1:0] tns_b;
  logic [2:0]       count_b;
  logic [2:0]       ferr_b;
  logic             kind_b;
  logic             rng_b;

  logic [63:0]      acc_next;
  logic [TNS_W-1:0] tns_next;
  logic [2:0]       count_next;
  logic [2:0]       ferr_next;
  logic             rng_next;

  logic [63:0]      acc_step;
  logic [TNS_W-1:0] tns_step;
  step_flags_t      int_flags;
  step_flags_t      time_flags;

  logic advance;
  out_t res;

  // s1 moves on unless it closes a field and the result slot is blocked
  assign advance    = !s1.last || !result_valid || !result_stall;
  assign byte_stall = s1_valid && !advance;

  assign acc_b   = fopen ? acc   : '0;
  assign tns_b   = fopen ? tns   : '0;
  assign count_b = fopen ? count : '0;
  assign ferr_b  = fopen ? ferr  : ERR_NONE;
  assign kind_b  = fopen ? fkind : s1.kind;
  assign rng_b   = fopen ? rng   : 1'b0;

  bcdf_int_step u_int (
    .acc       (acc_b),
    .data_byte (s1.data_byte),
    .acc_new   (acc_step),
    .flags     (int_flags)
  );

  bcdf_time_step u_time (
    .tns       (tns_b),
    .idx       (count_b),
    .data_byte (s1.data_byte),
    .tns_new   (tns_step),
    .flags     (time_flags)
  );

  always_comb begin
    acc_next   = acc_b;
    tns_next   = tns_b;
    ferr_next  = ferr_b;
    rng_next   = rng_b;
    count_next = (count_b < COUNT_MAX) ? count_b + 3'd1 : count_b;

    if (!kind_b) begin
      // integer: first error sticks and freezes the accumulator
      if (ferr_b == ERR_NONE) begin
        if (int_flags.digit_bad) begin
          ferr_next = ERR_DIGIT;
        end else if (int_flags.overflow) begin
          ferr_next = ERR_OVERFLOW;
        end else begin
          acc_next = acc_step;
        end
      end
    end else if (count_b < TIME_BYTES) begin
      // time: bytes past the sixth are ignored
      tns_next = tns_step;
      rng_next = rng_b | time_flags.range_bad;
      if ((ferr_b == ERR_NONE) && time_flags.digit_bad) begin
        ferr_next = ERR_DIGIT;
      end
    end

    res.value = '0;
    if (!kind_b) begin
      res.error = ferr_next;
      if (ferr_next == ERR_NONE) begin
        res.value = acc_next;
      end
    end else if (count_next != TIME_BYTES) begin
      res.error = ERR_LENGTH;
    end else if (ferr_next != ERR_NONE) begin
      res.error = ferr_next;
    end else if (rng_next) begin
      res.error = ERR_RANGE;
    end else begin
      res.error = ERR_NONE;
      res.value = {{(64-TNS_W){1'b0}}, tns_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      fopen        <= 1'b0;
      fkind        <= 1'b0;
      count        <= '0;
      ferr         <= ERR_NONE;
      rng          <= 1'b0;
      acc          <= '0;
      tns          <= '0;
    end else begin
      if (!byte_stall) begin
        s1_valid <= byte_valid;
        if (byte_valid) begin
          s1 <= byte_req;
        end
      end

      if (s1_valid && advance) begin
        acc   <= acc_next;
        tns   <= tns_next;
        count <= count_next;
        ferr  <= ferr_next;
        rng   <= rng_next;
        fkind <= kind_b;
        fopen <= !s1.last;
      end

      if (s1_valid && advance && s1.last) begin
        result_valid <= 1'b1;
        result_req   <= res;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // an error result never carries a value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result_req.error == ERR_NONE) || (result_req.value == '0)))
    else $error("error result with nonzero value");

  // a fresh result only comes from a field's last byte
  a_res_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid && s1.last))
    else $error("result without a closing byte");

  // a blocked byte in the input register is held, not lost
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1)))
    else $error("blocked byte changed");

  // reset empties both stages and closes any field
  a_reset: assert property (@(posedge clk)
    rst |=> (!s1_valid && !result_valid && !fopen))
    else $error("state not cleared by reset");
`endif

endmodule

[src/bcdf_int_step.sv]
module bcdf_int_step
  import bcdf_pkg::*;
(
  input  logic [63:0] acc,
  input  logic [7:0]  data_byte,
  output logic [63:0] acc_new,
  output step_flags_t flags
);

  logic [3:0]  hi;
  logic [3:0]  lo;
  logic [6:0]  pair;
  logic [70:0] sum;

  assign hi   = data_byte[7:4];
  assign lo   = data_byte[3:0];
  // two digits at once: acc*100 + hi*10 + lo; overflow iff it exceeds 64 bits
  assign pair = {3'b000, hi} * 7'd10 + {3'b000, lo};
  assign sum  = {7'b0, acc} * 71'd100 + {64'b0, pair};

  assign acc_new         = sum[63:0];
  assign flags.digit_bad = (hi > 4'd9) || (lo > 4'd9);
  assign flags.overflow  = |sum[70:64];
  assign flags.range_bad = 1'b0;

endmodule

[src/bcdf_time_step.sv]
module bcdf_time_step
  import bcdf_pkg::*;
(
  input  logic [TNS_W-1:0] tns,
  input  logic [2:0]       idx,
  input  logic [7:0]       data_byte,
  output logic [TNS_W-1:0] tns_new,
  output step_flags_t      flags
);

  logic [3:0]   hi;
  logic [3:0]   lo;
  logic         range_bad;
  weight_pair_t w;

  assign hi = data_byte[7:4];
  assign lo = data_byte[3:0];
  assign w  = time_weights(idx);

  assign tns_new = tns + w.w_hi * {{(TNS_W-4){1'b0}}, hi}
                       + w.w_lo * {{(TNS_W-4){1'b0}}, lo};

  assign flags.digit_bad = (hi > 4'd9) || (lo > 4'd9);
  assign flags.overflow  = 1'b0;
  assign flags.range_bad = range_bad;

  // hour above 23, minute or second above 59 (digits assumed valid here;
  // a bad digit is reported ahead of range anyway)
  always_comb begin
    case (idx)
      3'd0:         range_bad = (hi > 4'd2) || ((hi == 4'd2) && (lo > 4'd3));
      3'd1, 3'd2:   range_bad = (hi > 4'd5);
      default:      range_bad = 1'b0;
    endcase
  end

endmodule

[sim/bcd_field_to_binary_tb.sv]
`timescale 1ns / 100ps

module bcd_field_to_binary_tb
  import bcdf_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int          BYTE_TARGET = 1100;
  // 2^64-1 as packed BCD, most significant byte first
  localparam logic [7:0] U64_MAX_BCD [10] = '{8'h18, 8'h44, 8'h67, 8'h44, 8'h07,
                                               8'h37, 8'h09, 8'h55, 8'h16, 8'h15};

  typedef struct {
    in_t req;
    bit  drain_first;  // hold this request until every result is back
  } byte_slot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_stall;
  in_t  byte_req = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_t result_req;

  bcd_field_to_binary dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_req     (byte_req),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_req   (result_req)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  byte_slot_t  bytes_to_send[$];
  logic [7:0]  staged_bytes[$];
  out_t        conversions_due[$];

  // Shadow copy of the converter state
  logic [63:0] int_acc = '0;
  logic [47:0] time_bytes = '0;
  logic [2:0]  field_bytes = '0;
  logic [2:0]  field_err = ERR_NONE;
  logic        field_is_time = 1'b0;
  logic        field_open = 1'b0;

  int unsigned cycle_cnt = 0;
  int          bytes_taken = 0;
  int          results_checked = 0;
  int          mismatches = 0;
  int          outcome_cnt [5] = '{default: 0};
  logic        byte_fired = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          stall_len;
  bit          long_hold_done = 1'b0;

  // Idle-free stretches: both sides run flat out while cycle_cnt[9:8] is 2'b11
  wire quiet = (cycle_cnt[9:8] == 2'b11);

  // Number of idle cycles to insert: mostly none or short, now and then long
  function automatic int pick_idle(input logic no_idle);
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 65) return 0;
    if (roll < 96) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rand_bcd_byte(input int spoil_pct);
    logic [3:0] hi, lo;
    hi = 4'($urandom_range(0, 9));
    lo = 4'($urandom_range(0, 9));
    if ($urandom_range(0, 99) < spoil_pct) begin
      if ($urandom_range(0, 1) != 0) hi = 4'($urandom_range(10, 15));
      else lo = 4'($urandom_range(10, 15));
    end
    return {hi, lo};
  endfunction

  function automatic logic [7:0] two_digits(input int v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // HH MM SS mmm uuu -> ns since midnight, or a range error
  function automatic logic [63:0] time_of_day_ns(input logic [47:0] t,
                                                 output logic [2:0] err);
    longint unsigned hh, mm, ss, ms, us;
    hh = t[47:44] * 10 + t[43:40];
    mm = t[39:36] * 10 + t[35:32];
    ss = t[31:28] * 10 + t[27:24];
    ms = t[23:20] * 100 + t[19:16] * 10 + t[15:12];
    us = t[11:8] * 100 + t[7:4] * 10 + t[3:0];
    if (hh > 23 || mm > 59 || ss > 59 || ms > 999 || us > 999) begin
      err = ERR_RANGE;
      return '0;
    end
    err = ERR_NONE;
    return (hh * 3600 + mm * 60 + ss) * 64'd1_000_000_000 + ms * 64'd1_000_000
           + us * 64'd1_000;
  endfunction

  // Advance the shadow state by one accepted byte; a closing byte queues its result
  task automatic fold_bcd_byte(input in_t r);
    logic [3:0]  hi, lo;
    logic [63:0] dig;
    logic [2:0]  e;
    out_t        res;
    hi = r.data_byte[7:4];
    lo = r.data_byte[3:0];
    if (!field_open) begin
      int_acc       = '0;
      time_bytes    = '0;
      field_bytes   = '0;
      field_err     = ERR_NONE;
      field_is_time = r.kind;
      field_open    = 1'b1;
    end
    if (!field_is_time) begin
      // both nibbles are checked before either digit is folded in
      if (field_err == ERR_NONE) begin
        if (hi > 4'd9 || lo > 4'd9) begin
          field_err = ERR_DIGIT;
        end else begin
          for (int k = 0; k < 2; k++) begin
            dig = (k == 0) ? 64'(hi) : 64'(lo);
            if (field_err == ERR_NONE) begin
              if (int_acc > (64'hFFFF_FFFF_FFFF_FFFF - dig) / 64'd10) field_err = ERR_OVERFLOW;
              else int_acc = int_acc * 64'd10 + dig;
            end
          end
        end
      end
    end else if (field_bytes < TIME_BYTES) begin
      time_bytes = {time_bytes[39:0], r.data_byte};
      if (field_err == ERR_NONE && (hi > 4'd9 || lo > 4'd9)) field_err = ERR_DIGIT;
    end
    if (field_bytes != COUNT_MAX) field_bytes = field_bytes + 3'd1;

    if (r.last) begin
      res.value = '0;
      if (!field_is_time) begin
        e = field_err;
        res.value = int_acc;
      end else if (field_bytes != TIME_BYTES) begin
        e = ERR_LENGTH;  // wrong length beats any other error
      end else if (field_err != ERR_NONE) begin
        e = field_err;
      end else begin
        res.value = time_of_day_ns(time_bytes, e);
      end
      if (e != ERR_NONE) res.value = '0;
      res.error = e;
      conversions_due.push_back(res);
      field_open = 1'b0;
    end
  endtask

  // Turn staged_bytes into one field; kind on later bytes is noise
  task automatic queue_field(input logic kind, input bit drain);
    byte_slot_t s;
    for (int i = 0; i < staged_bytes.size(); i++) begin
      s.req.kind      = (i == 0) ? kind : logic'($urandom_range(0, 1));
      s.req.data_byte = staged_bytes[i];
      s.req.last      = (i == staged_bytes.size() - 1);
      s.drain_first   = drain && (i == 0);
      bytes_to_send.push_back(s);
    end
    staged_bytes.delete();
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results outstanding", cycle_cnt,
               conversions_due.size());
      $display("bcd_field_to_binary_tb: FAIL");
      $finish;
    end
  end

  // Monitor: request acceptance on both channels, sampled at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      byte_fired <= 1'b0;
    end else begin
      byte_fired <= byte_valid && !byte_stall;
      if (result_valid && !result_stall) begin
        results_checked <= results_checked + 1;
        if (conversions_due.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected result: value %0d error %0d", result_req.value,
                     result_req.error);
        end else begin
          if (result_req.value !== conversions_due[0].value ||
              result_req.error !== conversions_due[0].error) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("result %0d: value exp %0d got %0d, error exp %0d got %0d",
                       results_checked, conversions_due[0].value, result_req.value,
                       conversions_due[0].error, result_req.error);
          end
          outcome_cnt[conversions_due[0].error] <= outcome_cnt[conversions_due[0].error] + 1;
          void'(conversions_due.pop_front());
        end
      end
      if (byte_valid && !byte_stall) begin
        fold_bcd_byte(byte_req);
        bytes_taken <= bytes_taken + 1;
      end
    end
  end

  // Byte sender: moves on only once the current request was taken
  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || byte_fired) begin
      if (gap_left != 0) begin
        gap_left   <= gap_left - 1;
        byte_valid <= 1'b0;
      end else if (bytes_to_send.size() == 0) begin
        byte_valid <= 1'b0;
      end else if (bytes_to_send[0].drain_first && conversions_due.size() != 0) begin
        byte_valid <= 1'b0;
      end else begin
        byte_req   <= bytes_to_send[0].req;
        byte_valid <= 1'b1;
        gap_left   <= pick_idle(quiet);
        void'(bytes_to_send.pop_front());
      end
    end
  end

  // Result receiver; one long hold-off lets the block back up into the byte side
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else if (!long_hold_done && results_checked >= 150) begin
      long_hold_done <= 1'b1;
      result_stall   <= 1'b1;
      stall_left     <= 400;
    end else begin
      stall_len = pick_idle(quiet);
      result_stall <= (stall_len != 0);
      if (stall_len != 0) stall_left <= stall_len - 1;
    end
  end

  initial begin
    int  len, hh, mm, ss, cut;
    int  queued;
    bit  is_time;

    // Directed: zero, bad nibbles in both halves, 2^64-1 exactly
    staged_bytes.push_back(8'h00);
    queue_field(1'b0, 1'b0);
    staged_bytes.push_back(8'h9A);
    staged_bytes.push_back(8'hF3);
    queue_field(1'b0, 1'b0);
    foreach (U64_MAX_BCD[i]) staged_bytes.push_back(U64_MAX_BCD[i]);
    queue_field(1'b0, 1'b0);
    // Latest time of day, a one-byte time field, an hour past 23
    staged_bytes = '{8'h23, 8'h59, 8'h59, 8'h99, 8'h99, 8'h99};
    queue_field(1'b1, 1'b0);
    staged_bytes.push_back(8'h00);
    queue_field(1'b1, 1'b0);
    staged_bytes = '{8'h24, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    queue_field(1'b1, 1'b0);

    queued = bytes_to_send.size();
    while (queued < BYTE_TARGET) begin
      is_time = ($urandom_range(0, 2) == 0);
      if (is_time) begin
        len = ($urandom_range(0, 99) < 85) ? 6 : $urandom_range(1, 9);
        hh  = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 99) : $urandom_range(0, 23);
        mm  = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
        ss  = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < 3) staged_bytes.push_back(rand_bcd_byte(100));
          else if (i == 0) staged_bytes.push_back(two_digits(hh));
          else if (i == 1) staged_bytes.push_back(two_digits(mm));
          else if (i == 2) staged_bytes.push_back(two_digits(ss));
          else staged_bytes.push_back(rand_bcd_byte(0));
        end
      end else if ($urandom_range(0, 99) < 8) begin
        // follow 2^64-1 for a while, then go random: lands on both sides of the limit
        cut = $urandom_range(4, 9);
        len = $urandom_range(10, 11);
        for (int i = 0; i < len; i++)
          staged_bytes.push_back(i < cut ? U64_MAX_BCD[i] : rand_bcd_byte(0));
      end else begin
        len = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 8) : $urandom_range(9, 12);
        for (int i = 0; i < len; i++) staged_bytes.push_back(rand_bcd_byte(4));
      end
      // the first random field, and an odd one after, waits for a full drain
      queue_field(logic'(is_time), queued == 26 || $urandom_range(0, 59) == 0);
      queued = bytes_to_send.size();
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (bytes_to_send.size() != 0 || byte_valid) @(posedge clk);
    while (conversions_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    mismatches = mismatches + conversions_due.size();
    $display("sent %0d BCD bytes, checked %0d results, %0d mismatches", bytes_taken,
             results_checked, mismatches);
    $display("outcomes: ok %0d, bad digit %0d, overflow %0d, time length %0d, range %0d",
             outcome_cnt[ERR_NONE], outcome_cnt[ERR_DIGIT], outcome_cnt[ERR_OVERFLOW],
             outcome_cnt[ERR_LENGTH], outcome_cnt[ERR_RANGE]);
    if (mismatches == 0) begin
      $display("bcd_field_to_binary_tb: PASS");
    end else begin
      $display("bcd_field_to_binary_tb: FAIL");
    end
    $finish;
  end

endmodule
